/* rtl/core/pqc_pkg.sv */
package pqc_pkg;

    localparam int MODE_W  = 2;
    localparam int SUBP_W  = 4;
    localparam int CENTP_W = 8;
    localparam int ELEMP_W = 3;
    localparam int VAL_W   = 16;
    localparam int CODE_W  = 8;
    localparam int DIST_W  = 35;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DECODE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SUB_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUB_DIM   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_BITS = 2'd2;

    localparam logic KIND_ENCODE = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_ENC_OUT,
        ST_DEC_RD,
        ST_DEC_OUT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic cnt_clr;
        logic cnt_step;
        logic scan_rd;
        logic dec_rd;
        logic out_enc;
        logic out_dec;
    } cmd_t;

    typedef struct packed {
        logic enc_start;
        logic dec_start;
        logic j_end;
        logic cnt_end;
        logic pipe_busy;
        logic slot_free;
    } sts_t;

endpackage

/* rtl/core/pqc_ctrl.sv */
module pqc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  pqc_pkg::sts_t sts,
    output pqc_pkg::cmd_t cmd
);
    import pqc_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && sts.enc_start) begin
                    state_next = ST_SCAN;
                end else if (s_valid && sts.dec_start) begin
                    state_next = ST_DEC_RD;
                end
            end
            ST_SCAN: begin
                if (sts.cnt_end) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) state_next = ST_ENC_OUT;
            end
            ST_ENC_OUT: begin
                if (sts.slot_free) state_next = ST_IDLE;
            end
            ST_DEC_RD: begin
                state_next = ST_DEC_OUT;
            end
            ST_DEC_OUT: begin
                if (sts.slot_free) state_next = sts.j_end ? ST_IDLE : ST_DEC_RD;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                cmd.cnt_clr  = 1'b1;
            end
            ST_SCAN: begin
                cmd.scan_rd  = 1'b1;
                cmd.cnt_step = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_ENC_OUT: begin
                cmd.out_enc = sts.slot_free;
            end
            ST_DEC_RD: begin
                cmd.dec_rd = 1'b1;
            end
            ST_DEC_OUT: begin
                cmd.out_dec  = sts.slot_free;
                cmd.cnt_step = sts.slot_free;
            end
            default: cmd = '0;
        endcase
    end

endmodule

/* rtl/core/pqc_dp.sv */
module pqc_dp #(
    parameter int MAX_SUB       = 16,
    parameter int MAX_SUB_DIM   = 8,
    parameter int MAX_CODE_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [pqc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pqc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    input  logic [pqc_pkg::MODE_W-1:0]      s_mode,
    input  logic [pqc_pkg::SUBP_W-1:0]      s_sub_index,
    input  logic [pqc_pkg::CENTP_W-1:0]     s_centroid_index,
    input  logic [pqc_pkg::ELEMP_W-1:0]     s_element_index,
    input  logic signed [pqc_pkg::VAL_W-1:0] s_value,
    input  logic [pqc_pkg::CODE_W-1:0]      s_code_in,
    input  logic                            m_ready,
    output logic                            m_valid,
    output logic                            m_kind,
    output logic [pqc_pkg::SUBP_W-1:0]      m_sub_out,
    output logic [pqc_pkg::CODE_W-1:0]      m_code_found,
    output logic [pqc_pkg::DIST_W-1:0]      m_min_distance,
    output logic signed [pqc_pkg::VAL_W-1:0] m_element_value,
    output logic                            m_last,
    input  pqc_pkg::cmd_t                   cmd,
    output pqc_pkg::sts_t                   sts
);
    import pqc_pkg::*;

    localparam int CENTS = 1 << MAX_CODE_BITS;
    localparam int DEPTH = MAX_SUB * CENTS * MAX_SUB_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (MAX_SUB > 1) ? $clog2(MAX_SUB) : 1;
    localparam int DW    = (MAX_SUB_DIM > 1) ? $clog2(MAX_SUB_DIM) : 1;
    localparam int CB    = MAX_CODE_BITS;
    localparam int MW    = $clog2(MAX_SUB + 1);
    localparam int DDW   = $clog2(MAX_SUB_DIM + 1);
    localparam int NBW   = $clog2(MAX_CODE_BITS + 1);
    localparam int SQ_W  = 2 * VAL_W;
    localparam int ACC_N = SQ_W + DW;
    localparam int ACC_W = (ACC_N > DIST_W) ? ACC_N : DIST_W;

    // configuration
    logic [4:0] sub_count_reg;
    logic [3:0] sub_dim_reg;
    logic [3:0] code_bits_reg;
    logic [MW-1:0]  m_eff;
    logic [DDW-1:0] d_eff;
    logic [NBW-1:0] nb_eff;
    logic [DW-1:0]  j_max;
    logic [CB-1:0]  k_max;

    always_comb begin
        if (sub_count_reg == '0) m_eff = MW'(1);
        else if (int'(sub_count_reg) > MAX_SUB) m_eff = MW'(MAX_SUB);
        else m_eff = MW'(sub_count_reg);
        if (sub_dim_reg == '0) d_eff = DDW'(1);
        else if (int'(sub_dim_reg) > MAX_SUB_DIM) d_eff = DDW'(MAX_SUB_DIM);
        else d_eff = DDW'(sub_dim_reg);
        if (code_bits_reg == '0) nb_eff = NBW'(1);
        else if (int'(code_bits_reg) > MAX_CODE_BITS) nb_eff = NBW'(MAX_CODE_BITS);
        else nb_eff = NBW'(code_bits_reg);
        j_max = DW'(d_eff - DDW'(1));
        k_max = {CB{1'b1}} >> (NBW'(CB) - nb_eff);
    end

    logic cfg_hit;
    assign cfg_hit = cfg_we && (cfg_index == CFG_SUB_COUNT || cfg_index == CFG_SUB_DIM
                                || cfg_index == CFG_CODE_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_count_reg <= 5'd8;
            sub_dim_reg   <= 4'd4;
            code_bits_reg <= 4'd8;
        end else if (cfg_we) begin
            priority case (cfg_index)
                CFG_SUB_COUNT: sub_count_reg <= cfg_data;
                CFG_SUB_DIM:   sub_dim_reg   <= cfg_data[3:0];
                CFG_CODE_BITS: code_bits_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // input side
    logic accept;
    assign accept = s_valid && cmd.in_ready;

    logic [DW-1:0] ep_reg;
    logic [SW-1:0] sp_reg;
    logic [SW-1:0] scan_sub_reg;
    logic [SW-1:0] dec_sub_reg;
    logic [CB-1:0] dec_code_reg;
    logic signed [VAL_W-1:0] buf_mem [MAX_SUB_DIM];

    logic          restart;
    logic [DW-1:0] ep_e;
    logic [SW-1:0] sp_e;
    logic          completes;
    logic          load_ok;

    always_comb begin
        restart   = (int'(ep_reg) >= int'(d_eff)) || (int'(sp_reg) >= int'(m_eff));
        ep_e      = restart ? '0 : ep_reg;
        sp_e      = restart ? '0 : sp_reg;
        completes = (int'(ep_e) + 1) >= int'(d_eff);
        load_ok   = (int'(s_sub_index) < MAX_SUB) && (int'(s_centroid_index) < CENTS)
                    && (int'(s_element_index) < MAX_SUB_DIM);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ep_reg <= '0;
            sp_reg <= '0;
            for (int i = 0; i < MAX_SUB_DIM; i++) buf_mem[i] <= '0;
        end else if (cfg_hit) begin
            ep_reg <= '0;
            sp_reg <= '0;
        end else if (accept && s_mode == MODE_ENCODE) begin
            buf_mem[ep_e] <= s_value;
            if (!completes) begin
                ep_reg <= DW'(ep_e + DW'(1));
            end else begin
                ep_reg <= '0;
                sp_reg <= ((int'(sp_e) + 1) >= int'(m_eff)) ? '0 : SW'(sp_e + SW'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_mode == MODE_ENCODE) scan_sub_reg <= sp_e;
        if (accept && s_mode == MODE_DECODE) begin
            dec_sub_reg  <= SW'(s_sub_index);
            dec_code_reg <= CB'(s_code_in) & k_max;
        end
    end

    assign sts.enc_start = (s_mode == MODE_ENCODE) && completes;
    assign sts.dec_start = (s_mode == MODE_DECODE) && (int'(s_sub_index) < int'(m_eff));

    // centroid and component counters
    logic [DW-1:0] j_reg;
    logic [CB-1:0] k_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.cnt_clr) begin
            j_reg <= '0;
            k_reg <= '0;
        end else if (cmd.cnt_step) begin
            if (j_reg == j_max) begin
                j_reg <= '0;
                k_reg <= CB'(k_reg + CB'(1));
            end else begin
                j_reg <= DW'(j_reg + DW'(1));
            end
        end
    end

    assign sts.j_end   = (j_reg == j_max);
    assign sts.cnt_end = (j_reg == j_max) && (k_reg == k_max);

    // codebook memory, one write and one registered read per cycle
    logic signed [VAL_W-1:0] book_mem [DEPTH];
    logic signed [VAL_W-1:0] rdata_reg;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic          rd_en;

    always_comb begin
        wr_en   = accept && (s_mode == MODE_LOAD) && load_ok;
        wr_addr = AW'((int'(s_sub_index) * CENTS + int'(s_centroid_index)) * MAX_SUB_DIM
                      + int'(s_element_index));
        rd_en   = cmd.scan_rd || cmd.dec_rd;
        if (cmd.scan_rd) begin
            rd_addr = AW'((int'(scan_sub_reg) * CENTS + int'(k_reg)) * MAX_SUB_DIM
                          + int'(j_reg));
        end else begin
            rd_addr = AW'((int'(dec_sub_reg) * CENTS + int'(dec_code_reg)) * MAX_SUB_DIM
                          + int'(j_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) book_mem[wr_addr] <= s_value;
        if (rd_en) rdata_reg <= book_mem[rd_addr];
    end

    // distance pipeline: read, square, accumulate
    logic          ta_v_reg, tb_v_reg;
    logic [DW-1:0] ta_j_reg;
    logic [CB-1:0] ta_k_reg, tb_k_reg;
    logic          ta_first_reg, ta_last_reg, tb_first_reg, tb_last_reg;
    logic [SQ_W-1:0]  sq_reg;
    logic [ACC_W-1:0] acc_reg, best_reg, acc_next;
    logic [CB-1:0]    best_k_reg;
    logic signed [VAL_W:0] diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ta_v_reg <= 1'b0;
            tb_v_reg <= 1'b0;
        end else begin
            ta_v_reg <= cmd.scan_rd;
            tb_v_reg <= ta_v_reg;
        end
    end

    assign diff = (VAL_W+1)'(buf_mem[ta_j_reg]) - (VAL_W+1)'(rdata_reg);

    always_ff @(posedge aclk) begin
        ta_j_reg     <= j_reg;
        ta_k_reg     <= k_reg;
        ta_first_reg <= (j_reg == '0);
        ta_last_reg  <= (j_reg == j_max);
        tb_k_reg     <= ta_k_reg;
        tb_first_reg <= ta_first_reg;
        tb_last_reg  <= ta_last_reg;
        sq_reg       <= SQ_W'(diff * diff);
    end

    assign acc_next = (tb_first_reg ? '0 : acc_reg) + ACC_W'(sq_reg);

    always_ff @(posedge aclk) begin
        if (tb_v_reg) begin
            acc_reg <= acc_next;
            // strict less-than keeps the lowest index on ties
            if (tb_last_reg && (tb_k_reg == '0 || acc_next < best_reg)) begin
                best_reg   <= acc_next;
                best_k_reg <= tb_k_reg;
            end
        end
    end

    assign sts.pipe_busy = ta_v_reg || tb_v_reg;

    // result register
    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_enc || cmd.out_dec) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_enc) begin
            m_kind          <= KIND_ENCODE;
            m_sub_out       <= SUBP_W'(scan_sub_reg);
            m_code_found    <= CODE_W'(best_k_reg);
            m_min_distance  <= DIST_W'(best_reg);
            m_element_value <= '0;
            m_last          <= (int'(scan_sub_reg) + 1) == int'(m_eff);
        end else if (cmd.out_dec) begin
            m_kind          <= KIND_DECODE;
            m_sub_out       <= SUBP_W'(dec_sub_reg);
            m_code_found    <= CODE_W'(dec_code_reg);
            m_min_distance  <= '0;
            m_element_value <= rdata_reg;
            m_last          <= (j_reg == j_max);
        end
    end

    assign m_valid       = m_valid_reg;
    assign sts.slot_free = !m_valid_reg || m_ready;

endmodule

/* rtl/core/product_quantizer_codebook_unit.sv */
// Product-quantizer codebook with nearest-centroid encoder. Codebook loads and encode
// components that do not close a subvector are taken in the idle state, ready for
// the next word straight after. The component that closes a subvector scans the
// subspace, 2^code_bits centroids of sub_dim components, through the single read
// port of the codebook memory, which delivers one component per cycle into a
// square-and-accumulate pipeline. A decode outputs its sub_dim components in turn.
// The codebook has no reset; every entry that an encode or decode touches must be
// loaded first. Results wait in an output register while the next word is taken.
module product_quantizer_codebook_unit #(
    parameter int MAX_SUB       = 16,
    parameter int MAX_SUB_DIM   = 8,
    parameter int MAX_CODE_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [pqc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pqc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pqc_pkg::MODE_W-1:0]      s_mode,
    input  logic [pqc_pkg::SUBP_W-1:0]      s_sub_index,
    input  logic [pqc_pkg::CENTP_W-1:0]     s_centroid_index,
    input  logic [pqc_pkg::ELEMP_W-1:0]     s_element_index,
    input  logic signed [pqc_pkg::VAL_W-1:0] s_value,
    input  logic [pqc_pkg::CODE_W-1:0]      s_code_in,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_kind,
    output logic [pqc_pkg::SUBP_W-1:0]      m_sub_out,
    output logic [pqc_pkg::CODE_W-1:0]      m_code_found,
    output logic [pqc_pkg::DIST_W-1:0]      m_min_distance,
    output logic signed [pqc_pkg::VAL_W-1:0] m_element_value,
    output logic                            m_last
);
    import pqc_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pqc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .sts     (sts),
        .cmd     (cmd)
    );

    pqc_dp #(
        .MAX_SUB       (MAX_SUB),
        .MAX_SUB_DIM   (MAX_SUB_DIM),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_mode           (s_mode),
        .s_sub_index      (s_sub_index),
        .s_centroid_index (s_centroid_index),
        .s_element_index  (s_element_index),
        .s_value          (s_value),
        .s_code_in        (s_code_in),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_kind           (m_kind),
        .m_sub_out        (m_sub_out),
        .m_code_found     (m_code_found),
        .m_min_distance   (m_min_distance),
        .m_element_value  (m_element_value),
        .m_last           (m_last),
        .cmd              (cmd),
        .sts              (sts)
    );

    assign s_ready = cmd.in_ready;

endmodule

/* rtl/core/pqc_checker.sv */
module pqc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [pqc_pkg::MODE_W-1:0]      s_mode,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_kind,
    input logic [pqc_pkg::CODE_W-1:0]      m_code_found,
    input logic [pqc_pkg::DIST_W-1:0]      m_min_distance,
    input logic signed [pqc_pkg::VAL_W-1:0] m_element_value
);
    import pqc_pkg::*;

    // a result never appears in the cycle right after an input word is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result raised right after input accept");

    // a load never causes a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_mode == MODE_LOAD && !m_valid |=> !m_valid)
        else $error("result after codebook load");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_DECODE |-> m_min_distance == '0)
        else $error("decoded word carries a distance");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ENCODE |-> m_element_value == '0)
        else $error("encoded word carries a component");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_found))
        else $error("stalled result word changed");

endmodule

bind product_quantizer_codebook_unit pqc_checker u_pqc_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_mode          (s_mode),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_kind          (m_kind),
    .m_code_found    (m_code_found),
    .m_min_distance  (m_min_distance),
    .m_element_value (m_element_value)
);
